// File: hw/rtl/double_ended_queue_core_macros.svh
// Assertion macros for the double-ended queue core.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Clocked check, switched off while reset is held.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue core.
// No dependencies; imported by the interfaces, the RTL modules and the bench.
package dq_pkg;

  localparam int DEPTH = 1024;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [31:0] data_t;
  typedef logic [CNT_W-1:0]   count_t;

  localparam data_t NO_VALUE = -32'sd1;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Broadcast to every cell; at most one strobe high, only for an item that executes.
  typedef struct packed {
    logic  add_front;
    logic  add_back;
    logic  take_front;
    logic  take_back;
    data_t value;
  } cell_ctrl_t;

  // What a cell shows its neighbours: occupancy, front-order and back-order entries.
  typedef struct packed {
    logic  occ;
    data_t fwd;
    data_t rev;
  } cell_link_t;

  // Status of the chain as seen by the control logic.
  typedef struct packed {
    cell_link_t c0;
    cell_link_t c1;
    logic       full;
  } chain_stat_t;

endpackage

// File: hw/rtl/dq_intf.sv
// Valid/ready channel interfaces for request and result items.
// Depends on dq_pkg.
interface dq_req_if;
  import dq_pkg::*;
  logic  valid;
  logic  ready;
  op_t   op;
  data_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface dq_rsp_if;
  import dq_pkg::*;
  logic   valid;
  logic   ready;
  data_t  popped;
  logic   pop_was_empty;
  logic   push_dropped;
  count_t count;
  logic   is_empty;
  data_t  front_value;
  data_t  back_value;

  modport source (output valid, output popped, output pop_was_empty, output push_dropped,
                  output count, output is_empty, output front_value, output back_value,
                  input ready);
  modport sink   (input valid, input popped, input pop_was_empty, input push_dropped,
                  input count, input is_empty, input front_value, input back_value,
                  output ready);
endinterface

// File: hw/rtl/dq_cell.sv
// One slot of the deque chain: front-order entry, back-order entry, occupancy.
// Depends on dq_pkg.
module dq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dq_pkg::cell_ctrl_t ctrl,
  input  dq_pkg::cell_link_t lft,
  input  dq_pkg::cell_link_t rgt,
  output dq_pkg::cell_link_t q
);
  import dq_pkg::*;

  logic  occ_r, occ_nxt;
  data_t fwd_r, fwd_nxt;
  data_t rev_r, rev_nxt;
  logic  first_free;

  // first empty slot: left neighbour full, this one free
  assign first_free = lft.occ & ~occ_r;

  always_comb begin
    fwd_nxt = fwd_r;
    rev_nxt = rev_r;
    occ_nxt = occ_r;
    if (ctrl.add_front) begin
      fwd_nxt = lft.fwd;
      if (first_free) rev_nxt = ctrl.value;
      occ_nxt = lft.occ;
    end else if (ctrl.add_back) begin
      rev_nxt = lft.rev;
      if (first_free) fwd_nxt = ctrl.value;
      occ_nxt = lft.occ;
    end else if (ctrl.take_front) begin
      fwd_nxt = rgt.fwd;
      occ_nxt = rgt.occ;
    end else if (ctrl.take_back) begin
      rev_nxt = rgt.rev;
      occ_nxt = rgt.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) occ_r <= 1'b0;
    else        occ_r <= occ_nxt;
  end

  always_ff @(posedge clk) begin
    fwd_r <= fwd_nxt;
    rev_r <= rev_nxt;
  end

  assign q = '{occ: occ_r, fwd: fwd_r, rev: rev_r};

endmodule

// File: hw/rtl/dq_chain.sv
// Row of DEPTH deque cells wired to their neighbours.
// Depends on dq_pkg and dq_cell.
module dq_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  dq_pkg::cell_ctrl_t  ctrl,
  output dq_pkg::chain_stat_t stat
);
  import dq_pkg::*;

  cell_link_t links [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t lft, rgt;

    if (i == 0) begin : g_first
      // the pushed item enters here on a shift in
      assign lft = '{occ: 1'b1, fwd: ctrl.value, rev: ctrl.value};
    end else begin : g_mid_l
      assign lft = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rgt = '{occ: 1'b0, fwd: links[i].fwd, rev: links[i].rev};
    end else begin : g_mid_r
      assign rgt = links[i+1];
    end

    dq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .lft   (lft),
      .rgt   (rgt),
      .q     (links[i])
    );
  end

  assign stat = '{c0: links[0], c1: links[1], full: links[DEPTH-1].occ};

endmodule

// File: hw/rtl/double_ended_queue_core.sv
// Top level of the double-ended queue core: control, count and result register.
// Depends on dq_pkg, dq_intf, dq_chain and the assertion macro header.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  in_req   | in  | valid/ready   | op, value
//  out_rsp  | out | valid/ready   | popped, pop_was_empty, push_dropped, count,
//           |     |               | is_empty, front_value, back_value
//
// One item per cycle unless stalled; its result appears in the output register the
// cycle after acceptance. Every cell of the chain shifts or loads in that same
// cycle. Reset (rst_n low, synchronous) empties the queue; no clearing pass is
// needed. in_req.ready falls only while a result is held and out_rsp.ready is low.
module double_ended_queue_core (
  input  logic     clk,
  input  logic     rst_n,
  dq_req_if.sink   in_req,
  dq_rsp_if.source out_rsp
);
  import dq_pkg::*;
  `include "double_ended_queue_core_macros.svh"

  // Storage: two mirrored chains inside each cell. fwd holds the queue front
  // first, rev holds it back first, so both ends always sit in cell 0.
  cell_ctrl_t  ctrl;
  chain_stat_t stat;

  count_t count_r, count_nxt;

  logic  accept, is_push, is_empty_now, run;
  data_t front_nxt, back_nxt, popped_nxt;

  logic   out_valid_r;
  data_t  popped_r, front_r, back_r;
  logic   was_empty_r, dropped_r, empty_r;
  count_t count_out_r;

  assign accept       = in_req.valid & in_req.ready;
  assign is_push      = (in_req.op == OP_PUSH_FRONT) || (in_req.op == OP_PUSH_BACK);
  assign is_empty_now = ~stat.c0.occ;
  // item takes effect unless a push meets a full queue or a pop an empty one
  assign run          = accept & (is_push ? ~stat.full : ~is_empty_now);

  assign ctrl = '{add_front:  run && (in_req.op == OP_PUSH_FRONT),
                  add_back:   run && (in_req.op == OP_PUSH_BACK),
                  take_front: run && (in_req.op == OP_POP_FRONT),
                  take_back:  run && (in_req.op == OP_POP_BACK),
                  value:      in_req.value};

  dq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // Count, popped value and the post-operation ends, taken from cells 0 and 1 or the pushed value; NO_VALUE when empty.
  always_comb begin
    count_nxt  = count_r;
    front_nxt  = stat.c0.fwd;
    back_nxt   = stat.c0.rev;
    popped_nxt = NO_VALUE;
    if (run) begin
      case (in_req.op)
        OP_PUSH_FRONT: begin
          count_nxt = count_r + CNT_W'(1);
          front_nxt = in_req.value;
          if (is_empty_now) back_nxt = in_req.value;
        end
        OP_PUSH_BACK: begin
          count_nxt = count_r + CNT_W'(1);
          back_nxt  = in_req.value;
          if (is_empty_now) front_nxt = in_req.value;
        end
        OP_POP_FRONT: begin
          count_nxt  = count_r - CNT_W'(1);
          popped_nxt = stat.c0.fwd;
          front_nxt  = stat.c1.fwd;
        end
        OP_POP_BACK: begin
          count_nxt  = count_r - CNT_W'(1);
          popped_nxt = stat.c0.rev;
          back_nxt   = stat.c1.rev;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
    if (count_nxt == '0) begin
      front_nxt = NO_VALUE;
      back_nxt  = NO_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept)             out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded on acceptance only
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r    <= popped_nxt;
      was_empty_r <= ~is_push & is_empty_now;
      dropped_r   <= is_push & stat.full;
      count_out_r <= count_nxt;
      empty_r     <= (count_nxt == '0);
      front_r     <= front_nxt;
      back_r      <= back_nxt;
    end
  end

  // output register frees up in the same cycle the result is taken
  assign in_req.ready          = ~out_valid_r | out_rsp.ready;
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.popped        = popped_r;
  assign out_rsp.pop_was_empty = was_empty_r;
  assign out_rsp.push_dropped  = dropped_r;
  assign out_rsp.count         = count_out_r;
  assign out_rsp.is_empty      = empty_r;
  assign out_rsp.front_value   = front_r;
  assign out_rsp.back_value    = back_r;

  `DQ_ASSERT(a_count_occ, (count_r == '0) == ~stat.c0.occ, "count disagrees with cell 0")
  `DQ_ASSERT(a_full_count, stat.full |-> (count_r == CNT_W'(DEPTH)), "full, count short")
  `DQ_ASSERT(a_run_moves, run |=> (count_r != $past(count_r)), "executed item left count unchanged")
  `DQ_ASSERT(a_accept_out, accept |=> out_valid_r, "accepted item produced no result")
  `DQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid_r && count_r == '0), "reset left state")

endmodule

// File: bench/tb_double_ended_queue_core.sv
`timescale 1ns / 100ps
// Self-checking bench for double_ended_queue_core: directed, fill/drain, back-pressure, random.
// Depends on dq_pkg and the dq_req_if / dq_rsp_if interfaces of the RTL.
module tb_double_ended_queue_core;
  import dq_pkg::*;

  localparam int IDX_W        = $clog2(DEPTH);
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off under pressure
  localparam int STALL_LIMIT  = 4000;  // cycles with no item moving before we give up
  localparam int DRAIN_ITEMS  = 64;    // pops taken back out after the fill
  localparam int RANDOM_ITEMS = 200;
  localparam int SEG_ITEMS    = 50;

  typedef logic [IDX_W-1:0] idx_t;

  // one expected result item
  typedef struct {
    data_t  popped;
    logic   pop_was_empty;
    logic   push_dropped;
    count_t count;
    logic   is_empty;
    data_t  front_value;
    data_t  back_value;
  } deque_result_t;

  logic clk;
  logic rst_n;

  dq_req_if req_ch ();
  dq_rsp_if rsp_ch ();

  double_ended_queue_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // shadow deque: ring contents, pointers and occupancy
  data_t  shadow_ring [DEPTH];
  idx_t   shadow_head;
  idx_t   shadow_tail;
  count_t shadow_count;

  deque_result_t pending_results [$];
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;

  // shared idling controls: no_idle gives a stretch with both sides flat out,
  // hold_go toggles to ask the receiver for a long hold-off
  logic        no_idle;
  logic        hold_go;
  logic        hold_seen;
  int unsigned hold_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Work out the result of one request and move the shadow state on.
  function automatic deque_result_t deque_apply(op_t op, data_t val);
    deque_result_t r;
    idx_t          back_idx;
    r.popped        = NO_VALUE;
    r.pop_was_empty = 1'b0;
    r.push_dropped  = 1'b0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count == count_t'(DEPTH)) begin
          r.push_dropped = 1'b1;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_head = shadow_head - 1'b1;
          shadow_ring[shadow_head] = val;
          shadow_count = shadow_count + 1'b1;
        end else begin
          shadow_ring[shadow_tail] = val;
          shadow_tail = shadow_tail + 1'b1;
          shadow_count = shadow_count + 1'b1;
        end
      end
      default: begin
        if (shadow_count == '0) begin
          r.pop_was_empty = 1'b1;
        end else if (op == OP_POP_FRONT) begin
          r.popped = shadow_ring[shadow_head];
          shadow_head = shadow_head + 1'b1;
          shadow_count = shadow_count - 1'b1;
        end else begin
          shadow_tail = shadow_tail - 1'b1;
          r.popped = shadow_ring[shadow_tail];
          shadow_count = shadow_count - 1'b1;
        end
      end
    endcase
    back_idx      = shadow_tail - 1'b1;
    r.count       = shadow_count;
    r.is_empty    = (shadow_count == '0);
    r.front_value = r.is_empty ? NO_VALUE : shadow_ring[shadow_head];
    r.back_value  = r.is_empty ? NO_VALUE : shadow_ring[back_idx];
    return r;
  endfunction

  // Mostly full-range random data, with the extremes, 0 and -1 mixed in.
  function automatic data_t pick_value();
    case ($urandom_range(15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return NO_VALUE;
      3:       return '0;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Offer one item, idling first at random; valid is only lowered by an idle
  // cycle, so back-to-back items keep it high without a second assignment.
  task automatic send_item(op_t op, data_t val);
    while (!no_idle && $urandom_range(99) < 37) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= val;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.insert(pending_results.size(), deque_apply(op, val));
  endtask

  // Withdraw the offer and let every outstanding result come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    deque_result_t w;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding: expected none, got count %0d",
                 $time, rsp_ch.count);
        mismatch_count++;
      end else begin
        w = pending_results[0];
        pending_results.delete(0);
        check_field("popped",        w.popped,        rsp_ch.popped);
        check_field("pop_was_empty", w.pop_was_empty, rsp_ch.pop_was_empty);
        check_field("push_dropped",  w.push_dropped,  rsp_ch.push_dropped);
        check_field("count",         w.count,         rsp_ch.count);
        check_field("is_empty",      w.is_empty,      rsp_ch.is_empty);
        check_field("front_value",   w.front_value,   rsp_ch.front_value);
        check_field("back_value",    w.back_value,    rsp_ch.back_value);
      end
    end
  end

  // Receiver: random stalls, a flat-out stretch, and a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen    <= hold_go;
      hold_left    <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= 37);
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Empty pops, the value extremes, a stored -1 and the head wrap from index 0.
  task automatic test_directed();
    send_item(OP_POP_FRONT,  data_t'($urandom));
    send_item(OP_POP_BACK,   data_t'($urandom));
    send_item(OP_PUSH_FRONT, 32'sh7fff_ffff);   // head wraps to DEPTH-1
    send_item(OP_PUSH_BACK,  32'sh8000_0000);
    send_item(OP_PUSH_FRONT, NO_VALUE);
    send_item(OP_PUSH_BACK,  '0);
    send_item(OP_PUSH_BACK,  NO_VALUE);
    send_item(OP_POP_FRONT,  '0);               // stored -1, not an empty pop
    send_item(OP_POP_BACK,   '1);               // stored -1 again from the back
    send_item(OP_POP_BACK,   '0);
    send_item(OP_POP_FRONT,  '1);
    send_item(OP_POP_FRONT,  '0);
    send_item(OP_POP_BACK,   '0);               // already empty: another empty pop
    send_item(OP_POP_FRONT,  '1);
    wait_drained();
  endtask

  // Fill the ring, push into it while full, then take part of it back out.
  task automatic test_fill_and_drain();
    while (shadow_count != count_t'(DEPTH))
      send_item($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
    send_item(OP_PUSH_FRONT, pick_value());
    send_item(OP_PUSH_BACK,  pick_value());
    send_item(OP_POP_BACK,   pick_value());
    send_item(OP_PUSH_FRONT, pick_value());      // refill to full from the other end
    send_item(OP_PUSH_BACK,  pick_value());      // dropped
    repeat (DRAIN_ITEMS)
      send_item($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, pick_value());
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering; input must stall.
  task automatic test_backpressure();
    hold_go <= ~hold_go;
    repeat (60)
      send_item(op_t'($urandom_range(3)), pick_value());
    wait_drained();
  endtask

  // Random requests in segments with a drifting push/pop mix so the count
  // sweeps up and down; the middle segments run with no idling at all.
  task automatic test_random_mix();
    int unsigned push_pct;
    op_t         op;
    for (int seg = 0; seg < RANDOM_ITEMS / SEG_ITEMS; seg++) begin
      no_idle  <= (seg == 1 || seg == 2);
      push_pct = $urandom_range(10, 90);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if ($urandom_range(99) < push_pct)
          op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
          op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        send_item(op, pick_value());
      end
    end
    no_idle <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_PUSH_FRONT;
    req_ch.value   = '0;
    rsp_ch.ready   = 1'b0;
    no_idle        = 1'b0;
    hold_go        = 1'b0;
    hold_seen      = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    shadow_head    = '0;
    shadow_tail    = '0;
    shadow_count   = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();

    wait_drained();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/dq_pkg.sv
hw/rtl/dq_intf.sv
hw/rtl/dq_cell.sv
hw/rtl/dq_chain.sv
hw/rtl/double_ended_queue_core.sv
bench/tb_double_ended_queue_core.sv
